>>> rtl/lsac_pkg.sv
package lsac_pkg;

	localparam int STAMP_W    = 64;
	localparam int TOTAL_W    = 32;
	localparam int ADDR_IN_W  = 64;
	localparam int CMD_W      = 2;
	localparam int CFG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int SET_CFG_W  = 4;
	localparam int BLK_CFG_W  = 6;
	localparam int WAY_CFG_W  = 4;
	// wide enough for the largest set_bits plus the largest block_bits
	localparam int SHIFT_W    = 7;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	localparam logic [SET_CFG_W-1:0] SET_BITS_RST    = 4'd5;
	localparam logic [BLK_CFG_W-1:0] BLOCK_BITS_RST  = 6'd5;
	localparam logic [WAY_CFG_W-1:0] WAYS_IN_USE_RST = 4'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN
	} state_t;

	// saturating add of a small increment to a running total
	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] cnt,
			input logic [1:0] inc);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, cnt} + {{(TOTAL_W - 1){1'b0}}, inc};
		return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
	endfunction

endpackage

>>> rtl/lru_set_associative_cache_model_core.sv
// Channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | cmd, address
// out      | out_valid / out_stall| was_hit, was_miss, was_eviction, second_hit,
//          |                      | hits_total, misses_total, evictions_total
// cfg      | cfg_we               | cfg_index, cfg_wdata
//
// Each transaction reads the set's row from the directory memory, then compares
// tags and writes the row back. A miss into a full set of e ways (e above one)
// adds an oldest-stamp search that reads one way per cycle, and the write-back
// follows once the search has settled.
// A modify folds its store part into the same write-back (it always hits).
// After reset a clearing pass writes every row with in_stall high. A result
// waits in the output register; the write-back of the next transaction holds
// while that register is full and stalled.
module lru_set_associative_cache_model_core #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lsac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsac_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lsac_pkg::CMD_W-1:0]       cmd,
	input  logic [lsac_pkg::ADDR_IN_W-1:0]   address,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             was_hit,
	output logic                             was_miss,
	output logic                             was_eviction,
	output logic                             second_hit,
	output logic [lsac_pkg::TOTAL_W-1:0]     hits_total,
	output logic [lsac_pkg::TOTAL_W-1:0]     misses_total,
	output logic [lsac_pkg::TOTAL_W-1:0]     evictions_total
);

	import lsac_pkg::*;

	localparam int TAG_W  = ADDR_WIDTH - 2;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int SCNT_W = $clog2(MAX_SET_BITS + 1);
	localparam int ROW_W  = MAX_WAYS * (1 + TAG_W + STAMP_W);

	// configuration registers
	logic [SET_CFG_W-1:0] set_bits_q;
	logic [BLK_CFG_W-1:0] block_bits_q;
	logic [WAY_CFG_W-1:0] ways_in_use_q;

	// effective (clamped) configuration
	logic [SCNT_W-1:0]       s_eff;
	logic [BLK_CFG_W-1:0]    b_eff;
	logic [WCNT_W-1:0]       e_eff;
	logic [MAX_SET_BITS-1:0] set_mask;

	// address split
	logic [ADDR_WIDTH-1:0]   addr_a;
	logic [ADDR_WIDTH-1:0]   set_sh;
	logic [ADDR_WIDTH-1:0]   tag_sh;
	logic [SHIFT_W-1:0]      tag_shift;
	logic [MAX_SET_BITS-1:0] acc_set;
	logic [TAG_W-1:0]        acc_tag;

	// transaction in flight
	state_t                  state_q, state_d;
	logic [CMD_W-1:0]        cmd_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0]        tag_q;
	logic [MAX_SET_BITS-1:0] clr_q;
	logic                    in_accept;

	// directory row
	logic [ROW_W-1:0]                   rd_row;
	logic [MAX_WAYS-1:0]                rd_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]     rd_tag;
	logic [MAX_WAYS-1:0][STAMP_W-1:0]   rd_stamp;
	logic [MAX_WAYS-1:0]                wr_valid;
	logic [MAX_WAYS-1:0][TAG_W-1:0]     wr_tag;
	logic [MAX_WAYS-1:0][STAMP_W-1:0]   wr_stamp;
	logic                               mem_we;
	logic [MAX_SET_BITS-1:0]            mem_waddr;
	logic [ROW_W-1:0]                   mem_wdata;

	// lookup and replacement
	logic               hit;
	logic [WAY_W-1:0]   hit_way;
	logic               empty;
	logic [WAY_W-1:0]   empty_way;
	logic               scan_start;
	logic               scan_busy;
	logic [WAY_W-1:0]   scan_victim;
	logic [WAY_W-1:0]   victim;
	logic               cmd_ok;
	logic               is_mod;
	logic               need_scan;
	logic               lk_hit;
	logic               lk_miss;
	logic               lk_evict;
	logic               out_free;
	logic               write_fire;

	// counters
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] new_stamp;
	logic [TOTAL_W-1:0] hits_q, misses_q, evicts_q;
	logic [TOTAL_W-1:0] hits_d, misses_d, evicts_d;
	logic [1:0]         hit_inc;

	// output register
	logic               out_valid_q;
	logic               was_hit_q, was_miss_q, was_evict_q, second_hit_q;
	logic [TOTAL_W-1:0] hits_out_q, misses_out_q, evicts_out_q;

	// ---------------------------------------------------------------------
	// Configuration: plain register writes, unchecked by the block; the user must write them only while idle
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= SET_BITS_RST;
			block_bits_q  <= BLOCK_BITS_RST;
			ways_in_use_q <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_wdata[SET_CFG_W-1:0];
				CFG_BLOCK_BITS:  block_bits_q  <= cfg_wdata[BLK_CFG_W-1:0];
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata[WAY_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp: zero acts as one, set bits and ways saturate at their maximum
	always_comb begin
		if (set_bits_q == '0) begin
			s_eff = SCNT_W'(1);
		end else if (int'(set_bits_q) > MAX_SET_BITS) begin
			s_eff = SCNT_W'(MAX_SET_BITS);
		end else begin
			s_eff = SCNT_W'(set_bits_q);
		end
		if (ways_in_use_q == '0) begin
			e_eff = WCNT_W'(1);
		end else if (int'(ways_in_use_q) > MAX_WAYS) begin
			e_eff = WCNT_W'(MAX_WAYS);
		end else begin
			e_eff = WCNT_W'(ways_in_use_q);
		end
		b_eff = (block_bits_q == '0) ? BLK_CFG_W'(1) : block_bits_q;
		for (int i = 0; i < MAX_SET_BITS; i++) begin
			set_mask[i] = (i < int'(s_eff));
		end
	end

	// Split the address: shifts at or past the address width give zero
	assign addr_a    = address[ADDR_WIDTH-1:0];
	assign set_sh    = addr_a >> b_eff;
	assign tag_shift = SHIFT_W'(s_eff) + SHIFT_W'(b_eff);
	assign tag_sh    = addr_a >> tag_shift;
	assign acc_set   = set_sh[MAX_SET_BITS-1:0] & set_mask;
	assign acc_tag   = tag_sh[TAG_W-1:0];

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= cmd;
			set_q <= acc_set;
			tag_q <= acc_tag;
		end
	end

	// ---------------------------------------------------------------------
	// Directory memory: one row per set, every way side by side
	// ---------------------------------------------------------------------
	lsac_dir_mem #(
		.ADDR_W(MAX_SET_BITS),
		.DATA_W(ROW_W)
	) u_dir_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_accept),
		.raddr (acc_set),
		.rdata (rd_row)
	);

	assign {rd_stamp, rd_tag, rd_valid} = rd_row;

	lsac_way_match #(
		.WAYS  (MAX_WAYS),
		.TAG_W (TAG_W),
		.WAY_W (WAY_W),
		.CNT_W (WCNT_W)
	) u_way_match (
		.valid     (rd_valid),
		.tags      (rd_tag),
		.tag       (tag_q),
		.ways_used (e_eff),
		.hit       (hit),
		.hit_way   (hit_way),
		.empty     (empty),
		.empty_way (empty_way)
	);

	lsac_lru_scan #(
		.WAYS  (MAX_WAYS),
		.WAY_W (WAY_W),
		.CNT_W (WCNT_W)
	) u_lru_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.stamps    (rd_stamp),
		.ways_used (e_eff),
		.busy      (scan_busy),
		.victim    (scan_victim)
	);

	assign cmd_ok    = (cmd_q == CMD_LOAD) || (cmd_q == CMD_STORE) || (cmd_q == CMD_MODIFY);
	assign is_mod    = (cmd_q == CMD_MODIFY);
	assign lk_hit    = cmd_ok && hit;
	assign lk_miss   = cmd_ok && !hit;
	assign lk_evict  = lk_miss && !empty;
	assign need_scan = lk_evict && (e_eff != WCNT_W'(1));
	assign out_free  = !out_valid_q || !out_stall;

	// Pick the line to refresh or fill
	always_comb begin
		if (hit) begin
			victim = hit_way;
		end else if (empty) begin
			victim = empty_way;
		end else if (e_eff == WCNT_W'(1)) begin
			victim = '0;
		end else begin
			victim = scan_victim;
		end
	end

	// A modify's store part hits the same line: advance the stamp twice
	assign new_stamp = stamp_q + (is_mod ? STAMP_W'(2) : STAMP_W'(1));

	always_comb begin
		wr_valid         = rd_valid;
		wr_tag           = rd_tag;
		wr_stamp         = rd_stamp;
		wr_valid[victim] = 1'b1;
		wr_tag[victim]   = tag_q;
		wr_stamp[victim] = new_stamp;
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MAX_SET_BITS'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {MAX_SET_BITS{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (need_scan) begin
					state_d = ST_SCAN;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!scan_busy && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		scan_start = 1'b0;
		write_fire = 1'b0;
		case (state_q)
			ST_CLEAR: begin
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_LOOKUP: begin
				scan_start = need_scan;
				write_fire = !need_scan && out_free;
			end
			ST_SCAN: begin
				write_fire = !scan_busy && out_free;
			end
			default: begin
			end
		endcase
	end

	// Clearing pass writes zero rows; otherwise write back the modified row
	assign mem_we    = (state_q == ST_CLEAR) || (write_fire && cmd_ok);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {wr_stamp, wr_tag, wr_valid};

	// ---------------------------------------------------------------------
	// Stamp and running totals
	// ---------------------------------------------------------------------
	assign hit_inc  = {1'b0, lk_hit} + {1'b0, is_mod};
	assign hits_d   = sat_add(hits_q, hit_inc);
	assign misses_d = sat_add(misses_q, {1'b0, lk_miss});
	assign evicts_d = sat_add(evicts_q, {1'b0, lk_evict});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (write_fire) begin
			if (cmd_ok) begin
				stamp_q <= new_stamp;
			end
			hits_q   <= hits_d;
			misses_q <= misses_d;
			evicts_q <= evicts_d;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: hold the result until the transaction completes
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_fire) begin
			was_hit_q    <= lk_hit;
			was_miss_q   <= lk_miss;
			was_evict_q  <= lk_evict;
			second_hit_q <= is_mod;
			hits_out_q   <= hits_d;
			misses_out_q <= misses_d;
			evicts_out_q <= evicts_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign was_hit         = was_hit_q;
	assign was_miss        = was_miss_q;
	assign was_eviction    = was_evict_q;
	assign second_hit      = second_hit_q;
	assign hits_total      = hits_out_q;
	assign misses_total    = misses_out_q;
	assign evictions_total = evicts_out_q;

`ifndef SYNTH
	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_LOOKUP))
		else $error("accepted transaction did not enter lookup");

	a_write_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		write_fire |=> out_valid)
		else $error("write-back did not load the output register");

	a_no_write_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !write_fire)
		else $error("write-back overran a stalled result");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_eviction) |-> (was_miss && !was_hit))
		else $error("eviction reported without a miss");
`endif

endmodule

>>> rtl/lsac_dir_mem.sv
module lsac_dir_mem #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 1016
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lsac_way_match.sv
module lsac_way_match #(
	parameter int WAYS  = 8,
	parameter int TAG_W = 62,
	parameter int WAY_W = 3,
	parameter int CNT_W = 4
) (
	input  logic [WAYS-1:0]            valid,
	input  logic [WAYS-1:0][TAG_W-1:0] tags,
	input  logic [TAG_W-1:0]           tag,
	input  logic [CNT_W-1:0]           ways_used,
	output logic                       hit,
	output logic [WAY_W-1:0]           hit_way,
	output logic                       empty,
	output logic [WAY_W-1:0]           empty_way
);

	// walk from the top way down so the lowest matching way wins
	always_comb begin
		hit       = 1'b0;
		hit_way   = '0;
		empty     = 1'b0;
		empty_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (CNT_W'(w) < ways_used) begin
				if (valid[w] && (tags[w] == tag)) begin
					hit     = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!valid[w]) begin
					empty     = 1'b1;
					empty_way = WAY_W'(w);
				end
			end
		end
	end

endmodule

>>> rtl/lsac_lru_scan.sv
module lsac_lru_scan #(
	parameter int WAYS  = 8,
	parameter int WAY_W = 3,
	parameter int CNT_W = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [WAYS-1:0][lsac_pkg::STAMP_W-1:0] stamps,
	input  logic [CNT_W-1:0]                     ways_used,
	output logic                                 busy,
	output logic [WAY_W-1:0]                     victim
);

	import lsac_pkg::*;

	logic [CNT_W-1:0]   idx_q;
	logic               busy_q;
	logic [STAMP_W-1:0] oldest_q;
	logic [WAY_W-1:0]   victim_q;
	logic [STAMP_W-1:0] cand;
	logic               last;

	assign cand = stamps[idx_q[WAY_W-1:0]];
	assign last = (idx_q == (ways_used - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= CNT_W'(1);
		end else if (busy_q) begin
			idx_q <= idx_q + CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// strict compare keeps the lower way on equal stamps
	always_ff @(posedge clk) begin
		if (start) begin
			oldest_q <= stamps[0];
			victim_q <= '0;
		end else if (busy_q && (cand < oldest_q)) begin
			oldest_q <= cand;
			victim_q <= idx_q[WAY_W-1:0];
		end
	end

	assign busy   = busy_q;
	assign victim = victim_q;

endmodule
